// ===== hw/rtl/smbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse map block parser package
// Sizes, codes and shared types of the sparse map extension block parser.
// ----------------------------------------------------------------------------
package smbp_pkg;

   localparam int ENTRIES_PER_BLOCK = 21;
   localparam int FIELD_BYTES       = 12;
   localparam int BLOCK_BYTES       = 512;

   localparam int ENTRY_AREA = ENTRIES_PER_BLOCK * 2 * FIELD_BYTES;
   localparam int POS_W      = $clog2(BLOCK_BYTES);
   localparam int FCNT_W     = $clog2(FIELD_BYTES);
   localparam int VALUE_W    = 36;
   localparam int RUN_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int DIGIT_W    = 3;

   localparam logic [POS_W-1:0]  ENTRY_END_POS = POS_W'(ENTRY_AREA);
   localparam logic [POS_W-1:0]  FLAG_POS      = POS_W'(ENTRY_AREA);
   localparam logic [POS_W-1:0]  LAST_POS      = POS_W'(BLOCK_BYTES - 1);
   localparam logic [FCNT_W-1:0] FIELD_LAST    = FCNT_W'(FIELD_BYTES - 1);
   localparam logic [RUN_W-1:0]  RUN_MAX       = '1;

   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_SEVEN = 8'h37;
   localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;

   typedef enum logic [1:0] {
      KIND_SEGMENT = 2'd0,
      KIND_MORE    = 2'd1,
      KIND_DONE    = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              stream_end;
   } in_word_type;

   typedef struct packed {
      logic step;
      logic digit;
      logic field_end;
      logic clear;
   } scan_ctrl_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [RUN_W-1:0]   length;
   } field_type;

endpackage

// ===== hw/rtl/smbp_if.sv =====
// ----------------------------------------------------------------------------
// Sparse map block parser channels
// Valid/ready channels for input bytes and for result words.
// ----------------------------------------------------------------------------
interface smbp_req_if;
   import smbp_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              stream_end;
   modport source (output valid, data_byte, stream_end, input ready);
   modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface smbp_rsp_if;
   import smbp_pkg::*;
   logic               valid;
   logic               ready;
   kind_type           kind;
   logic [VALUE_W-1:0] seg_offset;
   logic [VALUE_W-1:0] seg_length;
   modport source (output valid, kind, seg_offset, seg_length, input ready);
   modport sink   (input valid, kind, seg_offset, seg_length, output ready);
endinterface

// ===== hw/rtl/sparse_map_block_parser.sv =====
// ----------------------------------------------------------------------------
// Sparse map block parser
// A byte's result word is registered after the byte passes the input register.
// One byte per cycle while the result register is empty or taken, set by the
// single-pass parse stage that sits between the input register and the result
// register. Reset: synchronous, clears position, entry state and both valid flags.
// ----------------------------------------------------------------------------
module sparse_map_block_parser (
   input  logic       clock,
   input  logic       reset,
   smbp_req_if.sink   req_ch,
   smbp_rsp_if.source rsp_ch
);
   import smbp_pkg::*;

   logic          in_valid;
   in_word_type   in_word;
   logic          advance;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [FCNT_W-1:0]  fcnt_ff, fcnt_in;
   logic               field_odd_ff, field_odd_in;
   logic               held_valid_ff, held_valid_in;
   logic [VALUE_W-1:0] held_offset_ff, held_offset_in;
   logic               stopped_ff, stopped_in;
   logic               more_ff, more_in;

   logic               out_valid_ff, out_valid_in;
   kind_type           out_kind_ff, out_kind_in;
   logic [VALUE_W-1:0] out_offset_ff, out_offset_in;
   logic [VALUE_W-1:0] out_length_ff, out_length_in;
   logic               emit;

   logic          is_digit, active, field_end, block_last, restart, emit_seg;
   scan_ctrl_type scan_ctrl;
   field_type     closed;

   smbp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .advance_i (advance),
      .valid_o   (in_valid),
      .word_o    (in_word)
   );

   assign advance    = in_valid && (!out_valid_ff || rsp_ch.ready);
   assign is_digit   = (in_word.data_byte >= CHAR_ZERO) && (in_word.data_byte <= CHAR_SEVEN);
   assign active     = (pos_ff < ENTRY_END_POS) && !stopped_ff;
   assign field_end  = (fcnt_ff == FIELD_LAST);
   assign block_last = (pos_ff == LAST_POS);
   assign restart    = block_last || in_word.stream_end;

   always_comb begin
      scan_ctrl.step      = advance && active;
      scan_ctrl.digit     = is_digit;
      scan_ctrl.field_end = field_end;
      scan_ctrl.clear     = advance && restart;
   end

   smbp_field_scan u_field_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl_i   (scan_ctrl),
      .digit_i  (in_word.data_byte[DIGIT_W-1:0]),
      .closed_o (closed)
   );

   assign emit_seg = active && field_end && field_odd_ff && held_valid_ff
                     && (closed.length != '0) && (closed.value != '0);

   // entry and position state
   always_comb begin
      pos_in         = pos_ff;
      fcnt_in        = fcnt_ff;
      field_odd_in   = field_odd_ff;
      held_valid_in  = held_valid_ff;
      held_offset_in = held_offset_ff;
      stopped_in     = stopped_ff;
      more_in        = more_ff;
      if (advance) begin
         if (restart) begin
            pos_in        = '0;
            fcnt_in       = '0;
            field_odd_in  = 1'b0;
            held_valid_in = 1'b0;
            stopped_in    = 1'b0;
            more_in       = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (field_end) begin
               fcnt_in      = '0;
               field_odd_in = !field_odd_ff;
            end else begin
               fcnt_in = fcnt_ff + 1'b1;
            end
            if (active && field_end) begin
               if (!field_odd_ff) begin
                  if (closed.length == '0) begin
                     stopped_in = 1'b1;
                  end else begin
                     held_offset_in = closed.value;
                     held_valid_in  = 1'b1;
                  end
               end else begin
                  if (!emit_seg) begin
                     stopped_in = 1'b1;
                  end
                  held_valid_in = 1'b0;
               end
            end
            if (pos_ff == FLAG_POS) begin
               more_in = (in_word.data_byte == CHAR_ONE);
            end
         end
      end
   end

   // result word
   always_comb begin
      emit          = 1'b0;
      out_kind_in   = out_kind_ff;
      out_offset_in = '0;
      out_length_in = '0;
      priority if (block_last) begin
         emit = 1'b1;
         if (more_ff) begin
            out_kind_in = in_word.stream_end ? KIND_ERROR : KIND_MORE;
         end else begin
            out_kind_in = KIND_DONE;
         end
      end else if (in_word.stream_end) begin
         emit        = 1'b1;
         out_kind_in = KIND_ERROR;
      end else if (emit_seg) begin
         emit          = 1'b1;
         out_kind_in   = KIND_SEGMENT;
         out_offset_in = held_offset_ff;
         out_length_in = closed.value;
      end else begin
         emit = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         fcnt_ff       <= '0;
         field_odd_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         stopped_ff    <= 1'b0;
         more_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         fcnt_ff       <= fcnt_in;
         field_odd_ff  <= field_odd_in;
         held_valid_ff <= held_valid_in;
         stopped_ff    <= stopped_in;
         more_ff       <= more_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_offset_ff <= held_offset_in;
      if (advance && emit) begin
         out_kind_ff   <= out_kind_in;
         out_offset_ff <= out_offset_in;
         out_length_ff <= out_length_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.kind       = out_kind_ff;
   assign rsp_ch.seg_offset = out_offset_ff;
   assign rsp_ch.seg_length = out_length_ff;

   a_seg_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == KIND_SEGMENT |-> out_length_ff != '0)
      else $error("segment word with zero length");

   a_marker_payload: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff != KIND_SEGMENT |-> out_offset_ff == '0 && out_length_ff == '0)
      else $error("marker word with nonzero payload");

   a_held_in_size: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> field_odd_ff)
      else $error("held offset outside a size field");

   a_restart_pos: assert property (@(posedge clock) disable iff (reset)
      advance && emit && out_kind_in != KIND_SEGMENT |=> pos_ff == '0 && !stopped_ff)
      else $error("block state not cleared after marker word");

endmodule

// ===== hw/rtl/smbp_in_reg.sv =====
// ----------------------------------------------------------------------------
// Sparse map block parser input register
// Holds one input word until the parse stage takes it.
// ----------------------------------------------------------------------------
module smbp_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   smbp_req_if.sink              req_ch,
   input  logic                  advance_i,
   output logic                  valid_o,
   output smbp_pkg::in_word_type word_o
);
   import smbp_pkg::*;

   logic        valid_ff, valid_in;
   in_word_type word_ff;
   logic        take;

   assign req_ch.ready = !valid_ff || advance_i;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance_i) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff.data_byte  <= req_ch.data_byte;
         word_ff.stream_end <= req_ch.stream_end;
      end
   end

   assign valid_o = valid_ff;
   assign word_o  = word_ff;

endmodule

// ===== hw/rtl/smbp_field_scan.sv =====
// ----------------------------------------------------------------------------
// Sparse map block parser field scanner
// Tracks the current octal digit run and the longest run of one field.
// ----------------------------------------------------------------------------
module smbp_field_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  smbp_pkg::scan_ctrl_type      ctrl_i,
   input  logic [smbp_pkg::DIGIT_W-1:0] digit_i,
   output smbp_pkg::field_type          closed_o
);
   import smbp_pkg::*;

   field_type run_ff, run_in;
   field_type best_ff, best_in;
   field_type run_step, cand, closed;

   always_comb begin
      run_step.value  = {run_ff.value[VALUE_W-DIGIT_W-1:0], digit_i};
      run_step.length = (run_ff.length == RUN_MAX) ? RUN_MAX : run_ff.length + 1'b1;
      cand            = ctrl_i.digit ? run_step : run_ff;
      closed          = (cand.length > best_ff.length) ? cand : best_ff;
   end

   always_comb begin
      run_in  = run_ff;
      best_in = best_ff;
      priority if (ctrl_i.clear) begin
         run_in  = '0;
         best_in = '0;
      end else if (ctrl_i.step && ctrl_i.field_end) begin
         run_in  = '0;
         best_in = '0;
      end else if (ctrl_i.step && ctrl_i.digit) begin
         run_in  = run_step;
      end else if (ctrl_i.step) begin
         run_in  = '0;
         best_in = closed;
      end else begin
         run_in  = run_ff;
         best_in = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= '0;
         best_ff <= '0;
      end else begin
         run_ff  <= run_in;
         best_ff <= best_in;
      end
   end

   assign closed_o = closed;

endmodule

// ===== verif/smbp_map_checker.sv =====
// ----------------------------------------------------------------------------
// Sparse map block parser checker
// Watches the byte and result channels, predicts each result word from the
// accepted bytes with its own parse state, and compares field by field.
// ----------------------------------------------------------------------------
module smbp_map_checker (
   input  logic clock,
   input  logic reset,
   smbp_req_if  req_ch,
   smbp_rsp_if  rsp_ch,
   output int   fail_count,
   output int   pending,
   output int   seg_words,
   output int   more_words,
   output int   done_words,
   output int   error_words
);
   import smbp_pkg::*;

   typedef struct packed {
      kind_type           kind;
      logic [VALUE_W-1:0] offset;
      logic [VALUE_W-1:0] length;
   } map_word_type;

   map_word_type expected_words[$];

   logic [POS_W-1:0]   byte_pos;
   logic [VALUE_W-1:0] run_val;
   logic [RUN_W-1:0]   run_len;
   logic [VALUE_W-1:0] best_val;
   logic [RUN_W-1:0]   longest_len;
   logic [VALUE_W-1:0] held_off;
   logic               held_ok;
   logic               stopped;
   logic               more_flag;

   int fails;
   int kind_tally [4];

   initial begin
      fails = 0;
      for (int k = 0; k < 4; k++) kind_tally[k] = 0;
   end

   task automatic clear_parse();
      byte_pos    = '0;
      run_val     = '0;
      run_len     = '0;
      best_val    = '0;
      longest_len = '0;
      held_off    = '0;
      held_ok     = 1'b0;
      stopped     = 1'b0;
      more_flag   = 1'b0;
   endtask

   task automatic close_run();
      if (run_len > longest_len) begin
         best_val    = run_val;
         longest_len = run_len;
      end
      run_val = '0;
      run_len = '0;
   endtask

   task automatic parse_byte(input logic [BYTE_W-1:0] d, input logic fin);
      int           p;
      bit           emit;
      map_word_type w;
      p    = byte_pos;
      emit = 1'b0;
      w    = '{KIND_SEGMENT, '0, '0};
      if (p < ENTRY_AREA && !stopped) begin
         if (d >= CHAR_ZERO && d <= CHAR_SEVEN) begin
            run_val = {run_val[VALUE_W-DIGIT_W-1:0], d[DIGIT_W-1:0]};
            if (run_len != RUN_MAX) run_len = run_len + 1'b1;
         end else begin
            close_run();
         end
         if (p % FIELD_BYTES == FIELD_BYTES - 1) begin
            close_run();
            if (((p / FIELD_BYTES) % 2) == 0) begin
               if (longest_len == 0) begin
                  stopped = 1'b1;
               end else begin
                  held_off = best_val;
                  held_ok  = 1'b1;
               end
            end else begin
               if (!held_ok || longest_len == 0 || best_val == 0) begin
                  stopped = 1'b1;
               end else begin
                  emit = 1'b1;
                  w    = '{KIND_SEGMENT, held_off, best_val};
               end
               held_ok = 1'b0;
            end
            best_val    = '0;
            longest_len = '0;
         end
      end
      if (byte_pos == FLAG_POS) more_flag = (d == CHAR_ONE);
      if (byte_pos == LAST_POS) begin
         emit = 1'b1;
         if (more_flag) w = '{(fin ? KIND_ERROR : KIND_MORE), '0, '0};
         else w = '{KIND_DONE, '0, '0};
         clear_parse();
      end else if (fin) begin
         emit = 1'b1;
         w    = '{KIND_ERROR, '0, '0};
         clear_parse();
      end else begin
         byte_pos = byte_pos + 1'b1;
      end
      if (emit) expected_words.insert(expected_words.size(), w);
   endtask

   always @(posedge clock) begin
      map_word_type want;
      map_word_type seen;
      if (reset) begin
         clear_parse();
         expected_words.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = '{rsp_ch.kind, rsp_ch.seg_offset, rsp_ch.seg_length};
            kind_tally[seen.kind]++;
            if (expected_words.size() == 0) begin
               fails++;
               $display("%0t: unexpected word, expected none, got kind %0d offset %0d length %0d",
                        $time, seen.kind, seen.offset, seen.length);
            end else begin
               want = expected_words.pop_front();
               if (want.kind != seen.kind) begin
                  fails++;
                  $display("%0t: kind mismatch, expected %0d, got %0d",
                           $time, want.kind, seen.kind);
               end
               if (want.offset != seen.offset) begin
                  fails++;
                  $display("%0t: seg_offset mismatch, expected %0d, got %0d",
                           $time, want.offset, seen.offset);
               end
               if (want.length != seen.length) begin
                  fails++;
                  $display("%0t: seg_length mismatch, expected %0d, got %0d",
                           $time, want.length, seen.length);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) parse_byte(req_ch.data_byte, req_ch.stream_end);
      end
      fail_count  <= fails;
      pending     <= expected_words.size();
      seg_words   <= kind_tally[KIND_SEGMENT];
      more_words  <= kind_tally[KIND_MORE];
      done_words  <= kind_tally[KIND_DONE];
      error_words <= kind_tally[KIND_ERROR];
   end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Sparse map block parser testbench
// Feeds short broken streams, then random sparse maps built entry by entry
// (full, padded, tied and empty fields, zero sizes, continuation flags,
// truncations and missing next blocks) under random bursts and stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import smbp_pkg::*;

   localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [BYTE_W-1:0] NUL_CHAR   = 8'h00;
   localparam int FLAG_BYTE    = ENTRY_AREA;
   localparam int RANDOM_WORDS = 1700;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 400;

   typedef enum int {
      F_DIGITS, F_PADDED, F_TIE, F_MIXED, F_ZERO, F_EMPTY
   } field_fill_type;

   logic clock = 1'b0;
   logic reset;

   smbp_req_if req_ch ();
   smbp_rsp_if rsp_ch ();

   int fail_count, pending, seg_words, more_words, done_words, error_words;
   int bytes_sent = 0;
   int streams = 0;
   int burst_left = 0;

   logic [BYTE_W-1:0] blk [0:BLOCK_BYTES-1];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sparse_map_block_parser DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   smbp_map_checker map_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .fail_count  (fail_count),
      .pending     (pending),
      .seg_words   (seg_words),
      .more_words  (more_words),
      .done_words  (done_words),
      .error_words (error_words)
   );

   function automatic logic [BYTE_W-1:0] octal_char();
      return CHAR_ZERO + BYTE_W'($urandom_range(0, 7));
   endfunction

   function automatic logic [BYTE_W-1:0] other_char();
      int r;
      r = $urandom_range(0, 247);
      return (r >= CHAR_ZERO) ? BYTE_W'(r + 8) : BYTE_W'(r);
   endfunction

   task automatic put_field(input int base, input field_fill_type fill);
      int lead, len, a, gap, sel;
      logic [BYTE_W-1:0] pad;
      case (fill)
         F_DIGITS: begin
            sel = $urandom_range(0, 3);
            for (int i = 0; i < FIELD_BYTES; i++)
               blk[base+i] = (sel == 0) ? CHAR_SEVEN : octal_char();
         end
         F_PADDED: begin
            lead = $urandom_range(0, FIELD_BYTES - 2);
            pad  = $urandom_range(0, 1) ? SPACE_CHAR : CHAR_ZERO;
            for (int i = 0; i < FIELD_BYTES - 1; i++)
               blk[base+i] = (i < lead) ? pad : octal_char();
            blk[base+FIELD_BYTES-1] = $urandom_range(0, 1) ? NUL_CHAR : SPACE_CHAR;
         end
         F_TIE: begin
            len = $urandom_range(1, 5);
            a   = $urandom_range(0, FIELD_BYTES - 1 - 2 * len);
            gap = $urandom_range(1, FIELD_BYTES - 2 * len - a);
            for (int i = 0; i < FIELD_BYTES; i++) blk[base+i] = other_char();
            for (int j = 0; j < len; j++) begin
               blk[base+a+j]         = octal_char();
               blk[base+a+len+gap+j] = octal_char();
            end
         end
         F_MIXED: begin
            for (int i = 0; i < FIELD_BYTES; i++)
               blk[base+i] = $urandom_range(0, 1) ? octal_char() : other_char();
         end
         F_ZERO: begin
            lead = $urandom_range(0, FIELD_BYTES - 1);
            for (int i = 0; i < FIELD_BYTES; i++)
               blk[base+i] = (i < lead) ? SPACE_CHAR : CHAR_ZERO;
         end
         default: begin
            sel = $urandom_range(0, 2);
            for (int i = 0; i < FIELD_BYTES; i++)
               blk[base+i] = (sel == 0) ? NUL_CHAR : (sel == 1) ? SPACE_CHAR : other_char();
         end
      endcase
   endtask

   task automatic build_block(input bit more);
      int good, base, r;
      good = ($urandom_range(0, 3) == 0) ? ENTRIES_PER_BLOCK
                                         : $urandom_range(0, ENTRIES_PER_BLOCK);
      for (int e = 0; e < ENTRIES_PER_BLOCK; e++) begin
         base = e * 2 * FIELD_BYTES;
         if (e < good) begin
            put_field(base, field_fill_type'($urandom_range(0, 4)));
            put_field(base + FIELD_BYTES, field_fill_type'($urandom_range(0, 3)));
         end else if (e == good) begin
            r = $urandom_range(0, 2);
            put_field(base, (r == 0) ? F_EMPTY : field_fill_type'($urandom_range(0, 4)));
            put_field(base + FIELD_BYTES, (r == 0) ? field_fill_type'($urandom_range(0, 5)) :
                                          (r == 1) ? F_EMPTY : F_ZERO);
         end else begin
            put_field(base, field_fill_type'($urandom_range(0, 5)));
            put_field(base + FIELD_BYTES, field_fill_type'($urandom_range(0, 5)));
         end
      end
      if (more) begin
         blk[FLAG_BYTE] = CHAR_ONE;
      end else begin
         r = $urandom_range(0, 254);
         blk[FLAG_BYTE] = (r >= CHAR_ONE) ? BYTE_W'(r + 1) : BYTE_W'(r);
         if ($urandom_range(0, 1) == 0) blk[FLAG_BYTE] = CHAR_ZERO;
      end
      for (int i = FLAG_BYTE + 1; i < BLOCK_BYTES; i++)
         blk[i] = BYTE_W'($urandom_range(0, 255));
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] d, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= d;
      req_ch.stream_end <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_block(input int cut, input bit end_last);
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         if (i == cut) begin
            push_byte(blk[i], 1'b1);
            return;
         end
         push_byte(blk[i], (i == BLOCK_BYTES - 1) && end_last);
      end
   endtask

   // receiver: random stretches of ready with short stalls, one long hold-off
   initial begin
      int run, stall;
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && bytes_sent >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         run = $urandom_range(1, 30);
         rsp_ch.ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      int iter, pick, nblk, cut;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.data_byte  <= '0;
      req_ch.stream_end <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // short broken streams: byte extremes, digit overflow, non-octal digits
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b1);
      for (int i = 0; i < FIELD_BYTES; i++) push_byte(CHAR_SEVEN, 1'b0);
      push_byte(CHAR_SEVEN, 1'b1);
      for (int i = 0; i < 10; i++) push_byte(CHAR_ZERO + BYTE_W'((i + 8) % 10), i == 9);
      streams = 4;

      iter = 0;
      while (bytes_sent < RANDOM_WORDS) begin
         pick = (iter == 0) ? 0 : (iter == 1) ? 50 : $urandom_range(0, 99);
         if (pick < 45) begin
            nblk = (iter == 0) ? 2 : $urandom_range(1, 2);
            for (int b = 0; b < nblk; b++) begin
               build_block(b < nblk - 1);
               send_block(-1, (b == nblk - 1) && (iter == 0 || $urandom_range(0, 1)));
            end
         end else if (pick < 60) begin
            nblk = (iter == 1) ? 1 : $urandom_range(1, 2);
            for (int b = 0; b < nblk; b++) begin
               build_block(1'b1);
               send_block(-1, b == nblk - 1);
            end
         end else if (pick < 68) begin
            for (int i = 0; i < BLOCK_BYTES; i++) blk[i] = BYTE_W'($urandom_range(0, 255));
            send_block($urandom_range(0, 1) ? -1 : $urandom_range(0, BLOCK_BYTES - 1),
                       $urandom_range(0, 1));
         end else begin
            if ($urandom_range(0, 2) == 0) begin
               build_block(1'b1);
               send_block(-1, 1'b0);
            end
            build_block($urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0:       cut = $urandom_range(0, 2 * FIELD_BYTES - 1);
               1:       cut = $urandom_range(FLAG_BYTE, BLOCK_BYTES - 1);
               default: cut = $urandom_range(0, FLAG_BYTE - 1);
            endcase
            send_block(cut, 1'b0);
         end
         streams++;
         iter++;
      end

      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d input words in %0d streams, %0d result words checked:",
               bytes_sent, streams, seg_words + more_words + done_words + error_words);
      $display("  %0d segments, %0d block-continue, %0d map-complete, %0d incomplete errors",
               seg_words, more_words, done_words, error_words);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
